FILE: hw/rtl/tobe_pkg.sv
// Shared types and constants for the timestamp-ordered event builder.
`default_nettype none
package tobe_pkg;

  localparam int TIME_W = 48;
  localparam int SRC_W = 12;
  localparam int EN_W = 24;
  localparam int EVCNT_W = 32;
  localparam int HITS_W = 8;
  localparam int WIN_W = 32;
  localparam int BOARD_SCALE = 10;

  localparam logic CFG_WIN_EN = 1'b0;
  localparam logic CFG_WINDOW = 1'b1;

  typedef struct packed {
    logic [EN_W-1:0]   ea;
    logic [EN_W-1:0]   eb;
    logic [SRC_W-1:0]  src;
    logic [TIME_W-1:0] t;
  } hit_t;

  typedef struct packed {
    logic last;
    hit_t hit;
  } emit_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_TOP_RD,
    ST_TOP_CMP,
    ST_FL_RD,
    ST_FL_CMP,
    ST_EMIT,
    ST_DN_RD,
    ST_DN_CMP,
    ST_WR_ITEM
  } state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tobe_ctrl.sv
// Heap storage and the sequencer that walks it for insert, replace and extract.
`default_nettype none
module tobe_ctrl #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire logic              item_flush,
  input  wire tobe_pkg::hit_t    item_hit,
  output logic                   emit_valid,
  input  wire logic              emit_ready,
  output tobe_pkg::emit_req_t    emit_req
);
  import tobe_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = AW + 2;

  hit_t mem [QUEUE_DEPTH];
  hit_t rda_r, rdb_r;
  logic [AW-1:0] ra, rb, waddr;
  logic we;
  hit_t wdata;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  hit_t item_r, item_nxt;
  emit_req_t emit_r, emit_nxt;
  logic flush_r, flush_nxt;
  logic dn_r, dn_nxt;

  logic [AW-1:0] parent;
  logic [IW-1:0] lft, rgt, cnt_ext;
  logic lsm, rsm;
  logic [TIME_W-1:0] mtime;
  state_t after;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rda_r <= mem[ra];
    rdb_r <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      flush_r <= 1'b0;
      dn_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      flush_r <= flush_nxt;
      dn_r    <= dn_nxt;
    end
    idx_r  <= idx_nxt;
    item_r <= item_nxt;
    emit_r <= emit_nxt;
  end

  assign parent  = AW'((idx_r - AW'(1)) >> 1);
  assign lft     = IW'({idx_r, 1'b1});
  assign rgt     = lft + IW'(1);
  assign cnt_ext = IW'(cnt_r);
  assign lsm     = rda_r.t < item_r.t;
  assign mtime   = lsm ? rda_r.t : item_r.t;
  assign rsm     = (rgt < cnt_ext) && (rdb_r.t < mtime);
  assign after   = (flush_r && cnt_r != '0) ? ST_FL_RD : ST_IDLE;
  assign emit_req = emit_r;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    item_nxt   = item_r;
    emit_nxt   = emit_r;
    flush_nxt  = flush_r;
    dn_nxt     = dn_r;
    item_ready = 1'b0;
    emit_valid = 1'b0;
    ra         = '0;
    rb         = '0;
    we         = 1'b0;
    waddr      = idx_r;
    wdata      = item_r;
    case (state_r)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          flush_nxt = item_flush;
          if (item_flush) begin
            if (cnt_r != '0) begin
              state_nxt = ST_FL_RD;
            end
          end else begin
            item_nxt = item_hit;
            if (cnt_r < CW'(QUEUE_DEPTH)) begin
              idx_nxt   = AW'(cnt_r);
              cnt_nxt   = cnt_r + CW'(1);
              state_nxt = (cnt_r == '0) ? ST_WR_ITEM : ST_UP_RD;
            end else begin
              state_nxt = ST_TOP_RD;
            end
          end
        end
      end
      ST_UP_RD: begin
        ra = parent;
        state_nxt = ST_UP_CMP;
      end
      ST_UP_CMP: begin
        we = 1'b1;
        if (item_r.t < rda_r.t) begin
          wdata     = rda_r;
          idx_nxt   = parent;
          state_nxt = (parent == '0) ? ST_WR_ITEM : ST_UP_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TOP_RD: begin
        state_nxt = ST_TOP_CMP;
      end
      ST_TOP_CMP: begin
        emit_nxt.last = 1'b0;
        idx_nxt = '0;
        if (item_r.t < rda_r.t) begin
          emit_nxt.hit = item_r;
          dn_nxt = 1'b0;
        end else begin
          emit_nxt.hit = rda_r;
          dn_nxt = 1'b1;
        end
        state_nxt = ST_EMIT;
      end
      ST_FL_RD: begin
        rb = AW'(cnt_r - CW'(1));
        state_nxt = ST_FL_CMP;
      end
      ST_FL_CMP: begin
        emit_nxt.hit  = rda_r;
        emit_nxt.last = (cnt_r == CW'(1));
        dn_nxt        = (cnt_r != CW'(1));
        cnt_nxt       = cnt_r - CW'(1);
        item_nxt      = rdb_r;
        idx_nxt       = '0;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        emit_valid = 1'b1;
        if (emit_ready) begin
          state_nxt = dn_r ? ST_DN_RD : after;
        end
      end
      ST_DN_RD: begin
        ra = AW'(lft);
        rb = AW'(rgt);
        state_nxt = (lft >= cnt_ext) ? ST_WR_ITEM : ST_DN_CMP;
      end
      ST_DN_CMP: begin
        we = 1'b1;
        if (rsm) begin
          wdata     = rdb_r;
          idx_nxt   = AW'(rgt);
          state_nxt = ST_DN_RD;
        end else if (lsm) begin
          wdata     = rda_r;
          idx_nxt   = AW'(lft);
          state_nxt = ST_DN_RD;
        end else begin
          state_nxt = after;
        end
      end
      ST_WR_ITEM: begin
        we = 1'b1;
        state_nxt = after;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/tobe_evt.sv
// Event tagging of emitted hits, configuration registers and the result register.
`default_nettype none
module tobe_evt #(
  parameter int MAX_HITS_PER_EVENT = 200
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [tobe_pkg::WIN_W-1:0]    cfg_data,
  input  wire logic                          emit_valid,
  output logic                               emit_ready,
  input  wire tobe_pkg::emit_req_t           emit_req,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output tobe_pkg::hit_t                     out_hit,
  output logic                               out_opens,
  output logic [tobe_pkg::EVCNT_W-1:0]       out_evnum,
  output logic [tobe_pkg::HITS_W-1:0]        out_index,
  output logic                               out_over,
  output logic                               out_last
);
  import tobe_pkg::*;

  localparam logic [HITS_W-1:0] MAX_HITS = HITS_W'(MAX_HITS_PER_EVENT);

  logic win_en_r, win_en_nxt;
  logic [WIN_W-1:0] win_r, win_nxt;
  logic open_r, open_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic [EVCNT_W-1:0] evcnt_r, evcnt_nxt;
  logic [HITS_W-1:0] hits_r, hits_nxt;
  logic valid_r, valid_nxt;
  hit_t hit_r, hit_nxt;
  logic opens_r, opens_nxt;
  logic [EVCNT_W-1:0] evnum_r, evnum_nxt;
  logic [HITS_W-1:0] index_r, index_nxt;
  logic over_r, over_nxt;
  logic last_r, last_nxt;

  logic take, opens, over;
  logic [TIME_W-1:0] tdiff;
  logic [HITS_W-1:0] hbase;
  logic [EVCNT_W-1:0] evc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_en_r <= 1'b1;
      win_r    <= WIN_W'(100);
      open_r   <= 1'b0;
      start_r  <= '0;
      evcnt_r  <= '0;
      hits_r   <= '0;
      valid_r  <= 1'b0;
    end else begin
      win_en_r <= win_en_nxt;
      win_r    <= win_nxt;
      open_r   <= open_nxt;
      start_r  <= start_nxt;
      evcnt_r  <= evcnt_nxt;
      hits_r   <= hits_nxt;
      valid_r  <= valid_nxt;
    end
    hit_r   <= hit_nxt;
    opens_r <= opens_nxt;
    evnum_r <= evnum_nxt;
    index_r <= index_nxt;
    over_r  <= over_nxt;
    last_r  <= last_nxt;
  end

  assign emit_ready = !valid_r || out_ready;
  assign take  = emit_valid && emit_ready;
  assign tdiff = emit_req.hit.t - start_r;
  assign opens = !win_en_r || !open_r || (emit_req.hit.t < start_r) ||
                 (tdiff > TIME_W'(win_r));
  assign hbase = opens ? '0 : hits_r;
  assign over  = hbase >= MAX_HITS;
  assign evc   = (opens && open_r) ? evcnt_r + EVCNT_W'(1) : evcnt_r;

  always_comb begin
    win_en_nxt = win_en_r;
    win_nxt    = win_r;
    open_nxt   = open_r;
    start_nxt  = start_r;
    evcnt_nxt  = evcnt_r;
    hits_nxt   = hits_r;
    valid_nxt  = valid_r && !out_ready;
    hit_nxt    = hit_r;
    opens_nxt  = opens_r;
    evnum_nxt  = evnum_r;
    index_nxt  = index_r;
    over_nxt   = over_r;
    last_nxt   = last_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_WIN_EN: win_en_nxt = cfg_data[0];
        CFG_WINDOW: win_nxt = cfg_data;
        default: win_nxt = win_r;
      endcase
    end
    if (take) begin
      valid_nxt = 1'b1;
      open_nxt  = 1'b1;
      evcnt_nxt = evc;
      hits_nxt  = over ? hbase : hbase + HITS_W'(1);
      if (opens) begin
        start_nxt = emit_req.hit.t;
      end
      hit_nxt   = emit_req.hit;
      opens_nxt = opens;
      evnum_nxt = evc;
      index_nxt = over ? MAX_HITS : hbase;
      over_nxt  = over;
      last_nxt  = emit_req.last;
    end
  end

  assign out_valid = valid_r;
  assign out_hit   = hit_r;
  assign out_opens = opens_r;
  assign out_evnum = evnum_r;
  assign out_index = index_r;
  assign out_over  = over_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

FILE: hw/rtl/timestamp_ordered_event_builder_unit.sv
// Push, heap not full: the new hit climbs from the next free slot until its parent is not later.
// Push, heap full: the new hit is emitted directly when earlier than the top, else the top is emitted.
// Flush: every stored hit is emitted from the top in time order, the last one with out_tlast set.
// Output stalls hold the sequencer in its emit state; in_tready is high only while the sequencer is idle.
// Synchronous active-low reset empties the heap, clears event state and loads
// window_enable = 1, time_window = 100.
`default_nettype none
module timestamp_ordered_event_builder_unit #(
  parameter int QUEUE_DEPTH = 32,
  parameter int MAX_HITS_PER_EVENT = 200
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // hit_time, board_number, channel_number, energy_before, energy_after, zero pad
  input  wire logic [111:0] in_tdata,
  // mode
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_time, detector_id, out_energy_before, out_energy_after, opens_event,
  // event_number, index_in_event, multiplicity_overflow, zero pad
  output logic [151:0]      out_tdata,
  output logic              out_tlast,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import tobe_pkg::*;

  hit_t in_hit, out_hit;
  emit_req_t emit_req;
  logic emit_valid, emit_ready;
  logic out_opens, out_over;
  logic [EVCNT_W-1:0] out_evnum;
  logic [HITS_W-1:0] out_index;

  assign in_hit.t   = in_tdata[47:0];
  assign in_hit.src = SRC_W'(SRC_W'(in_tdata[55:48]) * SRC_W'(BOARD_SCALE)
                      + SRC_W'(in_tdata[59:56]));
  assign in_hit.eb  = in_tdata[83:60];
  assign in_hit.ea  = in_tdata[107:84];

  tobe_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item_flush (in_tuser),
    .item_hit   (in_hit),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit_req   (emit_req)
  );

  tobe_evt #(.MAX_HITS_PER_EVENT(MAX_HITS_PER_EVENT)) u_evt (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit_req   (emit_req),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_hit    (out_hit),
    .out_opens  (out_opens),
    .out_evnum  (out_evnum),
    .out_index  (out_index),
    .out_over   (out_over),
    .out_last   (out_tlast)
  );

  assign out_tdata = {2'b00, out_over, out_index, out_evnum, out_opens,
                      out_hit.ea, out_hit.eb, out_hit.src, out_hit.t};

endmodule
`default_nettype wire

FILE: tb/timestamp_ordered_event_builder_unit_tb.sv
// Testbench for the timestamp-ordered event builder: heap ordering, event grouping and flushes.
`default_nettype none
module timestamp_ordered_event_builder_unit_tb;
  import tobe_pkg::*;

  localparam int DEPTH = 32;
  localparam int MAX_HITS = 200;

  typedef struct packed {
    logic [TIME_W-1:0]  t;
    logic [SRC_W-1:0]   id;
    logic [EN_W-1:0]    eb;
    logic [EN_W-1:0]    ea;
    logic               opens;
    logic [EVCNT_W-1:0] evnum;
    logic [HITS_W-1:0]  idx;
    logic               over;
    logic               last;
  } built_hit_t;

  class event_scoreboard;
    logic [TIME_W-1:0] h_t [DEPTH];
    logic [SRC_W-1:0]  h_id [DEPTH];
    logic [EN_W-1:0]   h_eb [DEPTH];
    logic [EN_W-1:0]   h_ea [DEPTH];
    int unsigned       fill;
    logic [TIME_W-1:0] start_t;
    logic [EVCNT_W-1:0] ev_count;
    int unsigned       hits;
    bit                open_ev;
    bit                win_en;
    logic [WIN_W-1:0]  win;
    built_hit_t        expected_hits[$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       flushes;
    int unsigned       overflow_hits;

    function new();
      fill = 0;
      start_t = '0;
      ev_count = '0;
      hits = 0;
      open_ev = 0;
      win_en = 1;
      win = 100;
      mismatches = 0;
      checked = 0;
      flushes = 0;
      overflow_hits = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] val);
      if (idx == CFG_WIN_EN) win_en = val[0];
      else if (idx == CFG_WINDOW) win = val;
    endfunction

    function void swap_slots(int a, int b);
      logic [TIME_W-1:0] t;
      logic [SRC_W-1:0] s;
      logic [EN_W-1:0] x, y;
      t = h_t[a]; s = h_id[a]; x = h_eb[a]; y = h_ea[a];
      h_t[a] = h_t[b]; h_id[a] = h_id[b]; h_eb[a] = h_eb[b]; h_ea[a] = h_ea[b];
      h_t[b] = t; h_id[b] = s; h_eb[b] = x; h_ea[b] = y;
    endfunction

    function void sink(int i);
      int l, r, m;
      forever begin
        l = 2 * i + 1;
        r = l + 1;
        m = i;
        if (l < fill && h_t[l] < h_t[m]) m = l;
        if (r < fill && h_t[r] < h_t[m]) m = r;
        if (m == i) break;
        swap_slots(i, m);
        i = m;
      end
    endfunction

    function void assign_event(logic [TIME_W-1:0] t, logic [SRC_W-1:0] id,
                               logic [EN_W-1:0] eb, logic [EN_W-1:0] ea, bit last);
      built_hit_t e;
      bit opens, over;
      if (!win_en || !open_ev || t < start_t) opens = 1;
      else opens = (t - start_t) > {16'd0, win};
      if (opens) begin
        if (open_ev) ev_count = ev_count + 1;
        open_ev = 1;
        start_t = t;
        hits = 0;
      end
      over = hits >= MAX_HITS;
      e.t = t; e.id = id; e.eb = eb; e.ea = ea;
      e.opens = opens;
      e.evnum = ev_count;
      e.idx = over ? HITS_W'(MAX_HITS) : HITS_W'(hits);
      e.over = over;
      e.last = last;
      if (over) overflow_hits++;
      else hits++;
      expected_hits.insert(expected_hits.size(), e);
    endfunction

    function void note_input(logic flush, logic [111:0] d);
      logic [TIME_W-1:0] t;
      logic [SRC_W-1:0] id;
      logic [EN_W-1:0] eb, ea;
      logic [TIME_W-1:0] top_t;
      logic [SRC_W-1:0] top_id;
      logic [EN_W-1:0] top_eb, top_ea;
      int i, p;
      if (flush) begin
        flushes++;
        while (fill > 0) begin
          top_t = h_t[0]; top_id = h_id[0]; top_eb = h_eb[0]; top_ea = h_ea[0];
          fill--;
          if (fill > 0) begin
            swap_slots(0, fill);
            sink(0);
          end
          assign_event(top_t, top_id, top_eb, top_ea, fill == 0);
        end
        return;
      end
      t = d[47:0];
      id = d[55:48] * 12'd10 + d[59:56];
      eb = d[83:60];
      ea = d[107:84];
      if (fill < DEPTH) begin
        i = fill;
        h_t[i] = t; h_id[i] = id; h_eb[i] = eb; h_ea[i] = ea;
        fill++;
        while (i > 0) begin
          p = (i - 1) / 2;
          if (h_t[i] >= h_t[p]) break;
          swap_slots(i, p);
          i = p;
        end
      end else if (t < h_t[0]) begin
        assign_event(t, id, eb, ea, 0);
      end else begin
        assign_event(h_t[0], h_id[0], h_eb[0], h_ea[0], 0);
        h_t[0] = t; h_id[0] = id; h_eb[0] = eb; h_ea[0] = ea;
        sink(0);
      end
    endfunction

    function void check_result(logic [151:0] d, logic last);
      built_hit_t e, a;
      a.t = d[47:0]; a.id = d[59:48]; a.eb = d[83:60]; a.ea = d[107:84];
      a.opens = d[108]; a.evnum = d[140:109]; a.idx = d[148:141]; a.over = d[149];
      a.last = last;
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: %p", a);
        return;
      end
      e = expected_hits.pop_front();
      checked++;
      if (a.t !== e.t || a.id !== e.id || a.eb !== e.eb || a.ea !== e.ea ||
          a.opens !== e.opens || a.evnum !== e.evnum || a.idx !== e.idx ||
          a.over !== e.over || a.last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch on result %0d: expected %p, got %p", checked, e, a);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [111:0] in_tdata = '0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [151:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [31:0] cfg_data = '0;

  event_scoreboard sb = new();
  bit hold_req = 0;
  logic [TIME_W-1:0] clock_t = 0;

  timestamp_ordered_event_builder_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  task automatic send(logic flush, logic [TIME_W-1:0] t, logic [7:0] board, logic [3:0] ch,
                      logic [EN_W-1:0] eb, logic [EN_W-1:0] ea);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= flush;
    in_tdata <= {4'd0, ea, eb, ch, board, t};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic push_hit(logic [TIME_W-1:0] t);
    send(0, t, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
         24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)));
  endtask

  task automatic flush_heap();
    send(1, 48'({$urandom, $urandom}), 8'($urandom), 4'($urandom), 24'($urandom),
         24'($urandom));
  endtask

  task automatic settle();
    in_tvalid <= 0;
    do @(negedge clk); while (sb.expected_hits.size() != 0);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_hits(int n, int step);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 29) == 0) begin
        flush_heap();
      end else if ($urandom_range(0, 19) == 0) begin
        push_hit(48'({$urandom, $urandom}));
      end else begin
        clock_t = clock_t + $urandom_range(0, step);
        push_hit(clock_t - $urandom_range(0, step));
      end
    end
    flush_heap();
  endtask

  // Result-side ready: random stalls, plus one long hold-off on request.
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 0;
        repeat (400) @(negedge clk);
        hold_req = 0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
          out_tready <= 0;
          repeat (gap) @(negedge clk);
        end
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    #30000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Empty flush, field extremes and a late hit.
    flush_heap();
    send(0, 48'hFFFFFFFFFFFF, 8'd255, 4'd15, 24'hFFFFFF, 24'hFFFFFF);
    send(0, 48'd0, 8'd0, 4'd0, 24'd0, 24'd0);
    send(0, 48'd1000, 8'd255, 4'd9, 24'h000001, 24'h800000);
    flush_heap();
    send(0, 48'd500, 8'd7, 4'd3, 24'h123456, 24'h654321);
    flush_heap();
    settle();

    write_reg(CFG_WIN_EN, 32'd0);
    write_reg(CFG_WINDOW, 32'd0);
    clock_t = 48'd10000;
    random_hits(5, 30);
    settle();

    // Full heap with an early newcomer, then one long event past the multiplicity limit.
    write_reg(CFG_WIN_EN, 32'd1);
    write_reg(CFG_WINDOW, 32'hFFFFFFFF);
    hold_req = 1;
    for (int k = 0; k < 206; k++) begin
      if (k == 32) begin
        send(0, 48'd5, 8'd1, 4'd1, 24'd1, 24'd2);
      end else begin
        clock_t = clock_t + $urandom_range(0, 5);
        push_hit(clock_t);
      end
    end
    flush_heap();
    settle();

    write_reg(CFG_WINDOW, 32'd50);
    random_hits(5, 30);
    settle();
    write_reg(CFG_WINDOW, 32'd0);
    random_hits(4, 10);
    settle();

    $display("Covered %0d checked hits over %0d flushes, %0d beyond the multiplicity limit.",
             sb.checked, sb.flushes, sb.overflow_hits);
    $display("Settings visited: window building off, windows of 0, 50, 100 and the maximum.");
    if (sb.mismatches == 0 && sb.expected_hits.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
hw/rtl/tobe_pkg.sv
hw/rtl/tobe_ctrl.sv
hw/rtl/tobe_evt.sv
hw/rtl/timestamp_ordered_event_builder_unit.sv
tb/timestamp_ordered_event_builder_unit_tb.sv
